/* rtl/i2c_master_byte_engine_top_macros.svh */
// ---------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Shared concurrent assertion forms for the engine RTL.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH

// check an expression on every clock edge out of reset
`define I2CM_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check a same-cycle implication
`define I2CM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check a next-cycle implication
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/i2cm_pkg.sv */
// ---------------------------------------------------------------------------
// I2C master byte engine package
// Types and constants shared by the front, queue and engine.
// ---------------------------------------------------------------------------
package i2cm_pkg;

    localparam int CFG_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int BIT_COUNT_W = 4;

    localparam logic [15:0]            HALF_BIT_RESET = 16'd250;
    localparam logic [BIT_COUNT_W-1:0] BYTE_BITS      = 4'd8;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [15:0] {
        PH_IDLE       = 16'h0001,
        PH_ST_HIGH    = 16'h0002,
        PH_ST_LOW     = 16'h0004,
        PH_SP_LOW     = 16'h0008,
        PH_SP_HIGH    = 16'h0010,
        PH_WR_PRE     = 16'h0020,
        PH_WR_SETUP   = 16'h0040,
        PH_WR_HIGH    = 16'h0080,
        PH_WR_ACKPRE  = 16'h0100,
        PH_WR_ACKHIGH = 16'h0200,
        PH_TAIL       = 16'h0400,
        PH_RD_PRE     = 16'h0800,
        PH_RD_HIGH    = 16'h1000,
        PH_RD_LOW     = 16'h2000,
        PH_AK_SETUP   = 16'h4000,
        PH_AK_HIGH    = 16'h8000
    } t_phase;

    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_in;
    } t_entry;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_level;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic [CFG_W-1:0] wr_data;
    } t_cfg_wr;

endpackage

/* rtl/i2cm_front.sv */
// ---------------------------------------------------------------------------
// I2C master front stage
// Accepts tick items, decodes the command and registers them for the queue.
// ---------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd_valid,
    input  logic [1:0]        i_operation,
    input  logic [BYTE_W-1:0] i_tx_byte,
    input  logic              i_send_ack,
    input  logic              i_sda_in,
    output logic              o_push,
    input  logic              i_push_ready,
    output t_entry            o_entry
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    t_cmd   w_cmd;

    always_comb begin
        if (!i_cmd_valid) begin
            w_cmd = CMD_NONE;
        end else begin
            unique case (i_operation)
                OP_START: w_cmd = CMD_START;
                OP_STOP:  w_cmd = CMD_STOP;
                OP_WRITE: w_cmd = CMD_WRITE;
                default:  w_cmd = CMD_READ;
            endcase
        end
    end

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_entry = r_entry;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_valid && o_ready) begin
            n_valid          = 1'b1;
            n_entry.cmd      = w_cmd;
            n_entry.tx_byte  = i_tx_byte;
            n_entry.send_ack = i_send_ack;
            n_entry.sda_in   = i_sda_in;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

endmodule

/* rtl/i2cm_queue.sv */
// ---------------------------------------------------------------------------
// I2C master item queue
// Small FIFO that decouples the front stage from the engine.
// ---------------------------------------------------------------------------
`include "i2c_master_byte_engine_top_macros.svh"

module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_push_ready,
    input  t_entry i_entry,
    output logic   o_valid,
    input  logic   i_pop,
    output t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_valid      = (r_count != '0);
    assign o_entry      = r_mem[r_rd_ptr];
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `I2CM_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "queue overfilled")
    `I2CM_ASSERT_IMPL(a_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_wr_ptr == r_rd_ptr, "empty queue with split pointers")
    `I2CM_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_wr && !w_rd, r_count == $past(r_count) + 1'b1, "count missed a push")

endmodule

/* rtl/i2cm_engine.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine
// Steps the bus sequencer once per tick item and registers the result.
// ---------------------------------------------------------------------------
`include "i2c_master_byte_engine_top_macros.svh"

module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int DELAY_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_valid,
    output logic    o_pop,
    input  t_entry  i_entry,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [CFG_W-1:0]       r_half_bit;
    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [BIT_COUNT_W-1:0] r_bit_count;
    logic [BIT_COUNT_W-1:0] n_bit_count;
    logic [DELAY_WIDTH-1:0] r_delay;
    logic [DELAY_WIDTH-1:0] n_delay;
    logic [BYTE_W-1:0]      r_shift;
    logic [BYTE_W-1:0]      n_shift;
    logic                   r_scl;
    logic                   n_scl;
    logic                   r_sda;
    logic                   n_sda;
    logic                   r_ack_to_send;
    logic                   n_ack_to_send;
    logic [BYTE_W-1:0]      r_rx_byte;
    logic [BYTE_W-1:0]      n_rx_byte;
    logic                   r_ack_seen;
    logic                   n_ack_seen;
    logic                   n_done;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   w_step;
    logic [DELAY_WIDTH-1:0] w_load;
    logic [DELAY_WIDTH-1:0] w_dec;
    logic [BIT_COUNT_W-1:0] w_bc_inc;
    logic [BYTE_W-1:0]      w_wr_shift;
    logic [BYTE_W-1:0]      w_rd_shift;

    assign o_pop    = i_valid && (!r_out_valid || i_ready);
    assign w_step   = o_pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        if (r_half_bit == '0) begin
            w_load = DELAY_WIDTH'(1);
        end else if ((DELAY_WIDTH < CFG_W) && ((r_half_bit >> DELAY_WIDTH) != '0)) begin
            w_load = '1;
        end else begin
            w_load = DELAY_WIDTH'(r_half_bit);
        end
    end

    assign w_dec      = (r_delay != '0) ? r_delay - 1'b1 : '0;
    assign w_bc_inc   = r_bit_count + 1'b1;
    assign w_wr_shift = {r_shift[BYTE_W-2:0], 1'b0};
    assign w_rd_shift = {r_shift[BYTE_W-2:0], i_entry.sda_in};

    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_delay       = r_delay;
        n_shift       = r_shift;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_ack_to_send = r_ack_to_send;
        n_rx_byte     = r_rx_byte;
        n_ack_seen    = r_ack_seen;
        n_done        = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_entry.cmd != CMD_NONE) begin
                n_bit_count = '0;
                n_delay     = w_load;
            end
            unique case (i_entry.cmd)
                CMD_START: begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_phase = PH_ST_HIGH;
                end
                CMD_STOP: begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                    n_phase = PH_SP_LOW;
                end
                CMD_WRITE: begin
                    n_shift = i_entry.tx_byte;
                    n_scl   = 1'b0;
                    n_phase = PH_WR_PRE;
                end
                CMD_READ: begin
                    n_shift       = '0;
                    n_ack_to_send = i_entry.send_ack;
                    n_scl         = 1'b0;
                    n_sda         = 1'b1;
                    n_phase       = PH_RD_PRE;
                end
                default: begin
                end
            endcase
        end else begin
            n_delay = w_dec;
            if (w_dec == '0) begin
                n_delay = w_load;
                unique case (r_phase)
                    PH_ST_HIGH: begin
                        n_sda   = 1'b0;
                        n_phase = PH_ST_LOW;
                    end
                    PH_ST_LOW: begin
                        n_scl   = 1'b0;
                        n_delay = w_dec;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    PH_SP_LOW: begin
                        n_sda   = 1'b1;
                        n_phase = PH_SP_HIGH;
                    end
                    PH_SP_HIGH: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_delay = w_dec;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    PH_WR_PRE: begin
                        n_sda   = r_shift[BYTE_W-1];
                        n_phase = PH_WR_SETUP;
                    end
                    PH_WR_SETUP: begin
                        n_scl   = 1'b1;
                        n_phase = PH_WR_HIGH;
                    end
                    PH_WR_HIGH: begin
                        n_scl       = 1'b0;
                        n_shift     = w_wr_shift;
                        n_bit_count = w_bc_inc;
                        if (w_bc_inc >= BYTE_BITS) begin
                            n_phase = PH_WR_ACKPRE;
                        end else begin
                            n_sda   = w_wr_shift[BYTE_W-1];
                            n_phase = PH_WR_SETUP;
                        end
                    end
                    PH_WR_ACKPRE: begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_phase = PH_WR_ACKHIGH;
                    end
                    PH_WR_ACKHIGH: begin
                        n_ack_seen = i_entry.sda_in;
                        n_scl      = 1'b0;
                        n_phase    = PH_TAIL;
                    end
                    PH_TAIL: begin
                        n_delay = w_dec;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    PH_RD_PRE: begin
                        n_scl   = 1'b1;
                        n_phase = PH_RD_HIGH;
                    end
                    PH_RD_HIGH: begin
                        n_shift     = w_rd_shift;
                        n_bit_count = w_bc_inc;
                        if (w_bc_inc >= BYTE_BITS) begin
                            n_rx_byte = w_rd_shift;
                        end
                        n_scl   = 1'b0;
                        n_phase = PH_RD_LOW;
                    end
                    PH_RD_LOW: begin
                        if (r_bit_count >= BYTE_BITS) begin
                            n_sda   = !r_ack_to_send;
                            n_phase = PH_AK_SETUP;
                        end else begin
                            n_scl   = 1'b1;
                            n_phase = PH_RD_HIGH;
                        end
                    end
                    PH_AK_SETUP: begin
                        n_scl   = 1'b1;
                        n_phase = PH_AK_HIGH;
                    end
                    PH_AK_HIGH: begin
                        n_scl   = 1'b0;
                        n_phase = PH_TAIL;
                    end
                    default: begin
                        n_delay = w_dec;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit    <= HALF_BIT_RESET;
            r_phase       <= PH_IDLE;
            r_bit_count   <= '0;
            r_delay       <= '0;
            r_shift       <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_ack_to_send <= 1'b0;
            r_rx_byte     <= '0;
            r_ack_seen    <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.wr_en) begin
                r_half_bit <= i_cfg.wr_data;
            end
            if (w_step) begin
                r_phase       <= n_phase;
                r_bit_count   <= n_bit_count;
                r_delay       <= n_delay;
                r_shift       <= n_shift;
                r_scl         <= n_scl;
                r_sda         <= n_sda;
                r_ack_to_send <= n_ack_to_send;
                r_rx_byte     <= n_rx_byte;
                r_ack_seen    <= n_ack_seen;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_step) begin
            r_out.scl_level <= n_scl;
            r_out.sda_level <= n_sda;
            r_out.busy_res  <= (n_phase != PH_IDLE);
            r_out.done_res  <= n_done;
            r_out.rx_byte   <= n_rx_byte;
            r_out.ack_level <= n_ack_seen;
        end
    end

    `I2CM_ASSERT_IMPL(a_delay_live, i_clk, i_rst_n, r_phase != PH_IDLE, r_delay != '0, "busy phase with spent delay")
    `I2CM_ASSERT_ALWAYS(a_bit_bound, i_clk, i_rst_n, r_bit_count <= BYTE_BITS, "bit count past one byte")
    `I2CM_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_out_valid && r_out.done_res, !r_out.busy_res, "done reported while busy")

endmodule

/* rtl/i2c_master_byte_engine_top.sv */
// ---------------------------------------------------------------------------
// I2C master byte engine top level
// Tick-driven I2C master: start, stop, write byte and read byte sequences.
// ---------------------------------------------------------------------------
// Every input item is one bus timing tick and yields exactly one result item
// with the SCL/SDA levels and status after that tick. One item is taken per
// clock while o_ready is high; the sequencer advances by one tick per popped
// item. Each item passes the front register, the queue and the result
// register. Each half-bit segment lasts i_cfg_wr_data ticks as last
// written (zero counts as one); write it only while the engine is idle.
// ---------------------------------------------------------------------------
module i2c_master_byte_engine_top
    import i2cm_pkg::*;
#(
    parameter int DELAY_WIDTH = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd_valid,
    input  logic [1:0]        i_operation,
    input  logic [BYTE_W-1:0] i_tx_byte,
    input  logic              i_send_ack,
    input  logic              i_sda_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_scl_level,
    output logic              o_sda_level,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [BYTE_W-1:0] o_rx_byte,
    output logic              o_ack_level
);

    t_entry  w_front_entry;
    t_entry  w_queue_entry;
    logic    w_push;
    logic    w_push_ready;
    logic    w_queue_valid;
    logic    w_pop;
    t_cfg_wr w_cfg;
    t_result w_result;

    assign w_cfg.wr_en   = i_cfg_wr_en;
    assign w_cfg.wr_data = i_cfg_wr_data;

    i2cm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd_valid  (i_cmd_valid),
        .i_operation  (i_operation),
        .i_tx_byte    (i_tx_byte),
        .i_send_ack   (i_send_ack),
        .i_sda_in     (i_sda_in),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_entry      (w_front_entry)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_entry      (w_front_entry),
        .o_valid      (w_queue_valid),
        .i_pop        (w_pop),
        .o_entry      (w_queue_entry)
    );

    i2cm_engine #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_queue_valid),
        .o_pop    (w_pop),
        .i_entry  (w_queue_entry),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_result)
    );

    assign o_scl_level = w_result.scl_level;
    assign o_sda_level = w_result.sda_level;
    assign o_busy_res  = w_result.busy_res;
    assign o_done_res  = w_result.done_res;
    assign o_rx_byte   = w_result.rx_byte;
    assign o_ack_level = w_result.ack_level;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// I2C master byte engine testbench
// Drives bus ticks carrying start, stop, write and read commands with random
// SDA samples, predicts the SCL/SDA levels and status of every tick, and
// compares each result item against the prediction under varied back-pressure
// and half-bit settings.
// ---------------------------------------------------------------------------
module testbench;
    import i2cm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int STAGE_TICKS    = 160;

    typedef enum logic [1:0] {SDA_ALL_LOW, SDA_ALL_HIGH, SDA_RANDOM} t_sda_drive;

    class t_tick_scoreboard;
        logic [CFG_W-1:0]  half_ticks;
        t_phase            phase;
        logic [3:0]        bit_cnt;
        logic [CFG_W-1:0]  delay_cnt;
        logic [7:0]        shift;
        logic              scl;
        logic              sda;
        logic              ack_drive;
        logic [7:0]        rx_data;
        logic              ack_sample;
        t_result           bus_levels[$];
        int                errors;

        function new();
            half_ticks = HALF_BIT_RESET;
            phase      = PH_IDLE;
            bit_cnt    = '0;
            delay_cnt  = '0;
            shift      = '0;
            scl        = 1'b1;
            sda        = 1'b1;
            ack_drive  = 1'b0;
            rx_data    = '0;
            ack_sample = 1'b1;
            errors     = 0;
        endfunction

        function void set_half_ticks(logic [CFG_W-1:0] value);
            half_ticks = value;
        endfunction

        function bit is_busy();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return bus_levels.size();
        endfunction

        function void enter(t_phase next);
            phase     = next;
            delay_cnt = (half_ticks == '0) ? 16'd1 : half_ticks;
        endfunction

        function void note_tick(logic cmd_valid, logic [1:0] op, logic [7:0] tx,
                                logic send_ack, logic sda_in);
            t_result lv;
            logic    done;
            done = 1'b0;
            if (phase == PH_IDLE) begin
                if (cmd_valid) begin
                    bit_cnt = '0;
                    case (op)
                        OP_START: begin
                            scl = 1'b1;
                            sda = 1'b1;
                            enter(PH_ST_HIGH);
                        end
                        OP_STOP: begin
                            scl = 1'b1;
                            sda = 1'b0;
                            enter(PH_SP_LOW);
                        end
                        OP_WRITE: begin
                            shift = tx;
                            scl   = 1'b0;
                            enter(PH_WR_PRE);
                        end
                        default: begin
                            shift     = '0;
                            ack_drive = send_ack;
                            scl       = 1'b0;
                            sda       = 1'b1;
                            enter(PH_RD_PRE);
                        end
                    endcase
                end
            end else begin
                if (delay_cnt != '0) delay_cnt = delay_cnt - 1'b1;
                if (delay_cnt == '0) begin
                    case (phase)
                        PH_ST_HIGH: begin
                            sda = 1'b0;
                            enter(PH_ST_LOW);
                        end
                        PH_ST_LOW: begin
                            scl   = 1'b0;
                            phase = PH_IDLE;
                            done  = 1'b1;
                        end
                        PH_SP_LOW: begin
                            sda = 1'b1;
                            enter(PH_SP_HIGH);
                        end
                        PH_SP_HIGH: begin
                            scl   = 1'b1;
                            sda   = 1'b1;
                            phase = PH_IDLE;
                            done  = 1'b1;
                        end
                        PH_WR_PRE: begin
                            sda = shift[7];
                            enter(PH_WR_SETUP);
                        end
                        PH_WR_SETUP: begin
                            scl = 1'b1;
                            enter(PH_WR_HIGH);
                        end
                        PH_WR_HIGH: begin
                            scl     = 1'b0;
                            shift   = shift << 1;
                            bit_cnt = bit_cnt + 1'b1;
                            if (bit_cnt >= BYTE_BITS) begin
                                enter(PH_WR_ACKPRE);
                            end else begin
                                sda = shift[7];
                                enter(PH_WR_SETUP);
                            end
                        end
                        PH_WR_ACKPRE: begin
                            sda = 1'b1;
                            scl = 1'b1;
                            enter(PH_WR_ACKHIGH);
                        end
                        PH_WR_ACKHIGH: begin
                            ack_sample = sda_in;
                            scl        = 1'b0;
                            enter(PH_TAIL);
                        end
                        PH_TAIL: begin
                            phase = PH_IDLE;
                            done  = 1'b1;
                        end
                        PH_RD_PRE: begin
                            scl = 1'b1;
                            enter(PH_RD_HIGH);
                        end
                        PH_RD_HIGH: begin
                            shift   = {shift[6:0], sda_in};
                            bit_cnt = bit_cnt + 1'b1;
                            if (bit_cnt >= BYTE_BITS) rx_data = shift;
                            scl = 1'b0;
                            enter(PH_RD_LOW);
                        end
                        PH_RD_LOW: begin
                            if (bit_cnt >= BYTE_BITS) begin
                                sda = ack_drive ? 1'b0 : 1'b1;
                                enter(PH_AK_SETUP);
                            end else begin
                                scl = 1'b1;
                                enter(PH_RD_HIGH);
                            end
                        end
                        PH_AK_SETUP: begin
                            scl = 1'b1;
                            enter(PH_AK_HIGH);
                        end
                        default: begin
                            scl = 1'b0;
                            enter(PH_TAIL);
                        end
                    endcase
                end
            end
            lv.scl_level = scl;
            lv.sda_level = sda;
            lv.busy_res  = (phase != PH_IDLE);
            lv.done_res  = done;
            lv.rx_byte   = rx_data;
            lv.ack_level = ack_sample;
            bus_levels.push_back(lv);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
            if (want !== seen) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_result seen);
            t_result want;
            if (bus_levels.size() == 0) begin
                $error("result item arrived with no prediction waiting");
                errors++;
                return;
            end
            want = bus_levels.pop_front();
            compare_field("scl_level", want.scl_level, seen.scl_level);
            compare_field("sda_level", want.sda_level, seen.sda_level);
            compare_field("busy_res", want.busy_res, seen.busy_res);
            compare_field("done_res", want.done_res, seen.done_res);
            compare_field("rx_byte", want.rx_byte, seen.rx_byte);
            compare_field("ack_level", want.ack_level, seen.ack_level);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CFG_W-1:0]  i_cfg_wr_data;
    logic              i_valid;
    logic              o_ready;
    logic              i_cmd_valid;
    logic [1:0]        i_operation;
    logic [BYTE_W-1:0] i_tx_byte;
    logic              i_send_ack;
    logic              i_sda_in;
    logic              o_valid;
    logic              i_ready;
    logic              o_scl_level;
    logic              o_sda_level;
    logic              o_busy_res;
    logic              o_done_res;
    logic [BYTE_W-1:0] o_rx_byte;
    logic              o_ack_level;

    t_tick_scoreboard sb;
    t_result          observed;
    int               send_idle_pct = 11;
    int               recv_idle_pct = 56;
    int               items_sent    = 0;
    int               quiet_cycles  = 0;

    i2c_master_byte_engine_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd_valid   (i_cmd_valid),
        .i_operation   (i_operation),
        .i_tx_byte     (i_tx_byte),
        .i_send_ack    (i_send_ack),
        .i_sda_in      (i_sda_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_scl_level   (o_scl_level),
        .o_sda_level   (o_sda_level),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_rx_byte     (o_rx_byte),
        .o_ack_level   (o_ack_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            observed.scl_level = o_scl_level;
            observed.sda_level = o_sda_level;
            observed.busy_res  = o_busy_res;
            observed.done_res  = o_done_res;
            observed.rx_byte   = o_rx_byte;
            observed.ack_level = o_ack_level;
            sb.check_result(observed);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic bus_sda(t_sda_drive mode);
        case (mode)
            SDA_ALL_LOW:  return 1'b0;
            SDA_ALL_HIGH: return 1'b1;
            default:      return 1'($urandom_range(1));
        endcase
    endfunction

    task automatic send_tick(input logic cmd_valid, input logic [1:0] op,
                             input logic [7:0] tx, input logic send_ack, input logic sda);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd_valid <= cmd_valid;
        i_operation <= op;
        i_tx_byte   <= tx;
        i_send_ack  <= send_ack;
        i_sda_in    <= sda;
        do @(posedge i_clk); while (!o_ready);
        sb.note_tick(cmd_valid, op, tx, send_ack, sda);
        items_sent++;
    endtask

    task automatic run_command(input logic [1:0] op, input logic [7:0] tx,
                               input logic send_ack, input t_sda_drive sda_mode,
                               input int noise_pct);
        send_tick(1'b1, op, tx, send_ack, bus_sda(sda_mode));
        while (sb.is_busy())
            send_tick($urandom_range(99) < noise_pct, 2'($urandom_range(3)), 8'($urandom),
                      1'($urandom_range(1)), bus_sda(sda_mode));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half_ticks(input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_half_ticks(value);
    endtask

    task automatic random_transaction();
        int kind;
        int count;
        kind = $urandom_range(99);
        if (kind < 80) begin
            run_command(OP_START, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
            count = $urandom_range(1, 4);
            repeat (count) begin
                run_command($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom),
                            1'($urandom_range(1)), SDA_RANDOM, 10);
                if ($urandom_range(7) == 0)
                    run_command(OP_START, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
            end
            run_command(OP_STOP, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
        end else if (kind < 92) begin
            run_command(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)),
                        SDA_RANDOM, 30);
        end else begin
            repeat ($urandom_range(1, 4))
                send_tick(1'b0, 2'($urandom_range(3)), 8'($urandom),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic run_random_stage();
        int target;
        for (int half = 0; half < 2; half++) begin
            write_half_ticks(half == 0 ? 16'd1 : 16'($urandom_range(2, 6)));
            target = items_sent + STAGE_TICKS / 2;
            while (items_sent < target) random_transaction();
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_cmd_valid   = 1'b0;
        i_operation   = OP_START;
        i_tx_byte     = '0;
        i_send_ack    = 1'b0;
        i_sda_in      = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset half-bit count, then zero which acts as one
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        write_half_ticks(16'd0);
        send_tick(1'b0, OP_WRITE, 8'hA5, 1'b1, 1'b0);
        send_tick(1'b0, OP_READ, 8'h5A, 1'b0, 1'b1);
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(OP_WRITE, 8'hFF, 1'b0, SDA_ALL_LOW, 0);
        run_command(OP_WRITE, 8'h00, 1'b1, SDA_ALL_HIGH, 0);
        run_command(OP_READ, 8'h00, 1'b1, SDA_ALL_HIGH, 0);
        run_command(OP_READ, 8'hFF, 1'b0, SDA_ALL_LOW, 0);
        // commands issued on every busy tick, the finishing one too, are dropped
        run_command(OP_START, 8'h3C, 1'b1, SDA_RANDOM, 100);
        run_command(OP_STOP, 8'hC3, 1'b0, SDA_RANDOM, 100);
        write_half_ticks(16'd2);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(OP_READ, 8'h81, 1'b1, SDA_RANDOM, 0);
        run_random_stage();

        send_idle_pct = 56;
        recv_idle_pct = 11;
        run_random_stage();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_stage();
        write_half_ticks(16'd3);
        run_command(OP_WRITE, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 5);
        wait_drained();

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
